@@ sv/b64d_pkg.sv @@
// shared types, constants and the alphabet lookup of the base64 decoder
package b64d_pkg;

  // bytes that one character can cause at most
  localparam int unsigned JobBytes = 3;
  // depth of the job queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw = $clog2(QueueDepth);
  localparam int unsigned QueueCw = $clog2(QueueDepth + 1);

  // characters with a fixed value
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [5:0] SextetPlus  = 6'd62;
  localparam logic [5:0] SextetSlash = 6'd63;
  localparam logic [5:0] SextetLowerBase = 6'd26;
  localparam logic [5:0] SextetDigitBase = 6'd52;

  // fill level of a full group
  localparam logic [1:0] GroupFull = 2'd3;

  // one queued job: up to three bytes, first byte in entry 0
  typedef struct packed {
    logic [JobBytes-1:0][7:0] bytes;
    logic [1:0]               count;
  } job_t;

  // alphabet lookup result
  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sextet_t;

  // map an ascii code to its six-bit value, ok low outside the alphabet
  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t r;
    logic [7:0] d;
    r = '0;
    d = '0;
    if (c >= "A" && c <= "Z") begin
      d = c - 8'("A");
      r.ok = 1'b1;
      r.value = d[5:0];
    end else if (c >= "a" && c <= "z") begin
      d = c - 8'("a");
      r.ok = 1'b1;
      r.value = d[5:0] + SextetLowerBase;
    end else if (c >= "0" && c <= "9") begin
      d = c - 8'("0");
      r.ok = 1'b1;
      r.value = d[5:0] + SextetDigitBase;
    end else if (c == CharPlus) begin
      r.ok = 1'b1;
      r.value = SextetPlus;
    end else if (c == CharSlash) begin
      r.ok = 1'b1;
      r.value = SextetSlash;
    end
    return r;
  endfunction

endpackage

@@ sv/base64_decoder.sv @@
// top level of the streaming base64 decoder
//
//   channel | direction | handshake               | payload
//   char    | in        | char_valid, char_stall  | char_code, end_of_message
//   byte    | out       | byte_valid, byte_stall  | data_byte, run_last
//
// one character is taken each cycle while the job queue has room
// a character's bytes are written into the job queue and then loaded into the byte register
// the back sends one byte a cycle from the queue head unless byte_stall holds it, up to three per job
// char_stall rises only when the queue holds four jobs
// rst is synchronous and clears the group state, empties the queue and the byte register
module base64_decoder import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] char_code,
  input  logic       end_of_message,
  output logic       byte_valid,
  input  logic       byte_stall,
  output logic [7:0] data_byte,
  output logic       run_last
);

  logic push;
  job_t job;
  logic full;
  logic head_valid;
  job_t head_job;
  logic pop;

  // classify and form jobs
  b64d_front u_front (
    .clk            (clk),
    .rst            (rst),
    .char_valid     (char_valid),
    .char_stall     (char_stall),
    .char_code      (char_code),
    .end_of_message (end_of_message),
    .queue_full     (full),
    .push           (push),
    .job            (job)
  );

  // job queue
  b64d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (job),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // serialise bytes
  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .run_last   (run_last)
  );

endmodule

@@ sv/b64d_front.sv @@
// front part: accepts characters, tracks the group and forms byte jobs
module b64d_front import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] char_code,
  input  logic       end_of_message,
  input  logic       queue_full,
  output logic       push,
  output job_t       job
);

  logic [2:0][5:0] sbuf;
  logic [2:0][5:0] sbuf_next;
  logic [1:0]      group_count;
  logic [1:0]      group_count_next;
  logic            stopped;
  logic            stopped_next;
  logic            accept;
  sextet_t         sx;
  logic [2:0][5:0] s_ins;
  logic [1:0]      n;

  assign char_stall = queue_full;
  assign accept = char_valid && !char_stall;

  // classify the character and work out the bytes and next state
  always_comb begin
    sx = sextet_of(char_code);
    s_ins = sbuf;
    if (group_count != GroupFull) begin
      s_ins[group_count] = sx.value;
    end
    job.bytes[0] = {s_ins[0], s_ins[1][5:4]};
    job.bytes[1] = {s_ins[1][3:0], s_ins[2][5:2]};
    job.bytes[2] = {s_ins[2][1:0], sx.value};
    n = 2'd0;
    sbuf_next = sbuf;
    group_count_next = group_count;
    stopped_next = stopped;
    if (!stopped) begin
      if (!sx.ok) begin
        // stop character flushes the partial group
        n = (group_count >= 2'd2) ? group_count - 2'd1 : 2'd0;
        group_count_next = 2'd0;
        stopped_next = 1'b1;
      end else if (group_count == GroupFull) begin
        n = 2'd3;
        group_count_next = 2'd0;
      end else begin
        sbuf_next = s_ins;
        group_count_next = group_count + 2'd1;
        if (end_of_message) begin
          n = group_count;
        end
      end
    end
    if (end_of_message) begin
      sbuf_next = '0;
      group_count_next = 2'd0;
      stopped_next = 1'b0;
    end
    job.count = n;
  end

  assign push = accept && (n != 2'd0);

  // group state
  always_ff @(posedge clk) begin
    if (rst) begin
      sbuf <= '0;
      group_count <= 2'd0;
      stopped <= 1'b0;
    end else if (accept) begin
      sbuf <= sbuf_next;
      group_count <= group_count_next;
      stopped <= stopped_next;
    end
  end

endmodule

@@ sv/b64d_queue.sv @@
// short job queue between front and back
module b64d_queue import b64d_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  job_t               entries [QueueDepth];
  logic [QueueAw-1:0] wr_ptr;
  logic [QueueAw-1:0] rd_ptr;
  logic [QueueCw-1:0] fill;

  assign full = (fill == QueueCw'(QueueDepth));
  assign head_valid = (fill != '0);
  assign head_job = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ sv/b64d_back.sv @@
// back part: sends the bytes of each job one per transfer
module b64d_back import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  output logic       byte_valid,
  input  logic       byte_stall,
  output logic [7:0] data_byte,
  output logic       run_last
);

  logic [1:0] idx;
  logic       load;
  logic       last;

  // next byte goes out when the output register is free
  assign load = head_valid && (!byte_valid || !byte_stall);
  assign last = (idx == head_job.count - 2'd1);
  assign pop = load && last;

  // control of the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
      byte_valid <= 1'b0;
    end else if (load) begin
      byte_valid <= 1'b1;
      idx <= last ? 2'd0 : idx + 2'd1;
    end else if (!byte_stall) begin
      byte_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_byte <= head_job.bytes[idx];
      run_last <= last;
    end
  end

endmodule

@@ sv/b64d_checker.sv @@
// port checks of the base64 decoder and their binding
module b64d_checker (
  input logic       clk,
  input logic       rst,
  input logic       char_valid,
  input logic       char_stall,
  input logic       byte_valid,
  input logic       byte_stall,
  input logic [7:0] data_byte,
  input logic       run_last
);

  // a stalled byte holds
  a_byte_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid && $stable(data_byte) && $stable(run_last))
    else $error("stalled byte changed");

  // reset empties the byte register
  a_rst_out: assert property (@(posedge clk) rst |=> !byte_valid)
    else $error("byte valid after reset");

  // reset leaves the queue with room
  a_rst_in: assert property (@(posedge clk) rst |=> !char_stall)
    else $error("input stalled after reset");

  // with no character offered and no stall, the input cannot stall the next cycle
  a_no_stall_after_idle: assert property (@(posedge clk) disable iff (rst)
    !char_stall && !byte_valid && !char_valid |=> !char_stall)
    else $error("stall without queued work");

endmodule

bind base64_decoder b64d_checker u_b64d_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_stall (char_stall),
  .byte_valid (byte_valid),
  .byte_stall (byte_stall),
  .data_byte  (data_byte),
  .run_last   (run_last)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the streaming base64 decoder
module tb_top import b64d_pkg::*; ();

  localparam int unsigned ItemTarget = 170;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned MaxShown = 10;
  localparam int unsigned DirRows = 25;
  localparam int unsigned IdlePct = 6;
  localparam int unsigned EndCycles = 10;

  // one decoded byte as it should leave the block
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } byte_exp_t;

  // one character to send, with its bytes typed in where typed is set
  typedef struct packed {
    logic [7:0]  code;
    logic        eom;
    logic        typed;
    logic [1:0]  n_bytes;
    logic [23:0] bytes;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       char_valid;
  logic       char_stall;
  logic [7:0] char_code;
  logic       end_of_message;
  logic       byte_valid;
  logic       byte_stall;
  logic [7:0] data_byte;
  logic       run_last;

  // decoder state as the testbench sees it
  logic [5:0] held_sextets [3];
  logic [1:0] held_count;
  bit         decode_halted;
  logic [6:0] sextet_lut [256];

  byte_exp_t  pending_bytes [$];
  byte_exp_t  seen_exp;
  int         mismatches;
  int         items_sent;
  int         idle_cycles;
  bit         idling_on;
  bit         drained_once;

  // directed characters: extremes, padding, stop codes and end-of-message cases
  stim_row_t directed_rows [DirRows] = '{
    '{"A",   1'b0, 1'b1, 2'd0, 24'h000000},
    '{"A",   1'b0, 1'b1, 2'd0, 24'h000000},
    '{"A",   1'b0, 1'b1, 2'd0, 24'h000000},
    '{"A",   1'b0, 1'b1, 2'd3, 24'h000000},
    '{"/",   1'b0, 1'b1, 2'd0, 24'h000000},
    '{"/",   1'b0, 1'b1, 2'd0, 24'h000000},
    '{"/",   1'b0, 1'b1, 2'd0, 24'h000000},
    '{"/",   1'b1, 1'b1, 2'd3, 24'hFFFFFF},
    '{"T",   1'b0, 1'b1, 2'd0, 24'h000000},
    '{"W",   1'b0, 1'b1, 2'd0, 24'h000000},
    '{"E",   1'b0, 1'b1, 2'd0, 24'h000000},
    '{"=",   1'b0, 1'b1, 2'd2, 24'h4D6100},
    '{8'hFF, 1'b0, 1'b1, 2'd0, 24'h000000},
    '{"Z",   1'b1, 1'b1, 2'd0, 24'h000000},
    '{"T",   1'b0, 1'b1, 2'd0, 24'h000000},
    '{"Q",   1'b1, 1'b1, 2'd1, 24'h4D0000},
    '{"z",   1'b0, 1'b0, 2'd0, 24'h000000},
    '{"+",   1'b0, 1'b0, 2'd0, 24'h000000},
    '{8'h00, 1'b0, 1'b0, 2'd0, 24'h000000},
    '{"0",   1'b1, 1'b1, 2'd0, 24'h000000},
    '{"9",   1'b0, 1'b0, 2'd0, 24'h000000},
    '{"a",   1'b0, 1'b0, 2'd0, 24'h000000},
    '{"5",   1'b1, 1'b0, 2'd0, 24'h000000},
    '{"M",   1'b0, 1'b1, 2'd0, 24'h000000},
    '{"=",   1'b1, 1'b1, 2'd0, 24'h000000}
  };

  base64_decoder DUT (
    .clk           (clk),
    .rst           (rst),
    .char_valid    (char_valid),
    .char_stall    (char_stall),
    .char_code     (char_code),
    .end_of_message(end_of_message),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .data_byte     (data_byte),
    .run_last      (run_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // character for a six-bit value in the standard alphabet
  function automatic logic [7:0] alpha_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < SextetLowerBase) return "A" + w;
    if (v < SextetDigitBase) return "a" + w - SextetLowerBase;
    if (v < SextetPlus) return "0" + w - SextetDigitBase;
    if (v == SextetPlus) return CharPlus;
    return CharSlash;
  endfunction

  function automatic stim_row_t make_row(input logic [7:0] code, input logic eom);
    stim_row_t r;
    r = '0;
    r.code = code;
    r.eom = eom;
    return r;
  endfunction

  task automatic clear_decode_state();
    held_sextets[0] = '0;
    held_sextets[1] = '0;
    held_sextets[2] = '0;
    held_count = '0;
    decode_halted = 1'b0;
  endtask

  // work out the bytes one character causes, first byte in bits 23:16
  task automatic predict_char(input logic [7:0] c, input logic eom, output int n,
                              output logic [23:0] bytes);
    logic [6:0] entry;
    entry = sextet_lut[c];
    n = 0;
    bytes = {held_sextets[0], held_sextets[1], held_sextets[2], entry[5:0]};
    if (!decode_halted) begin
      if (!entry[6]) begin
        // stop character: flush what is held, ignore the rest of the message
        n = (held_count >= 2) ? int'(held_count) - 1 : 0;
        held_count = '0;
        decode_halted = 1'b1;
      end else if (held_count == GroupFull) begin
        n = 3;
        held_count = '0;
      end else begin
        held_sextets[held_count] = entry[5:0];
        held_count = held_count + 2'd1;
        if (eom) begin
          bytes = {held_sextets[0], held_sextets[1], held_sextets[2], 6'd0};
          n = (held_count >= 2) ? int'(held_count) - 1 : 0;
        end
      end
    end
    if (eom) clear_decode_state();
  endtask

  // drive one character and record the bytes it should give
  task automatic send_char(input stim_row_t row);
    int          n;
    logic [23:0] bytes;
    byte_exp_t   e;
    @(negedge clk);
    while (idling_on && $urandom_range(99) < IdlePct) begin
      char_valid = 1'b0;
      @(negedge clk);
    end
    char_valid = 1'b1;
    char_code = row.code;
    end_of_message = row.eom;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    predict_char(row.code, row.eom, n, bytes);
    if (row.typed) begin
      n = row.n_bytes;
      bytes = row.bytes;
    end
    items_sent++;
    for (int i = 0; i < n; i++) begin
      e.value = bytes[23 - 8 * i -: 8];
      e.last = (i == n - 1);
      pending_bytes.push_back(e);
    end
  endtask

  // one random message: clean, padded, cut by a stray code, or plain noise
  task automatic send_message();
    int         len;
    int         kind;
    int         tail;
    logic [7:0] code;
    len = $urandom_range(14, 1);
    kind = $urandom_range(9);
    for (int i = 0; i < len; i++) begin
      code = (kind == 9) ? 8'($urandom_range(255)) : alpha_char(6'($urandom_range(63)));
      send_char(make_row(code, (kind < 6 || kind == 9) && i == len - 1));
    end
    if (kind >= 6 && kind < 9) begin
      code = "=";
      if (kind == 8) begin
        code = 8'($urandom_range(255));
        while (sextet_lut[code][6]) code = 8'($urandom_range(255));
      end
      tail = $urandom_range(3);
      send_char(make_row(code, tail == 0));
      for (int i = 0; i < tail; i++)
        send_char(make_row(8'($urandom_range(255)), i == tail - 1));
    end
  endtask

  // hold the sender until every outstanding byte has come out
  task automatic drain_bytes();
    @(negedge clk);
    char_valid = 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxShown) $display("%0t: %s", $realtime, msg);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    byte_stall = idling_on && ($urandom_range(99) < IdlePct);
  end

  // compare each byte transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) begin
      if (pending_bytes.size() == 0) begin
        log_mismatch($sformatf("unexpected byte %02h last %0b", data_byte, run_last));
      end else begin
        seen_exp = pending_bytes.pop_front();
        if (data_byte !== seen_exp.value || run_last !== seen_exp.last)
          log_mismatch($sformatf("expected byte %02h last %0b, got byte %02h last %0b",
                                 seen_exp.value, seen_exp.last, data_byte, run_last));
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((char_valid && !char_stall) || (byte_valid && !byte_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout after %0d cycles without a transfer", StallLimit);
    $display("== FAIL ==");
    $finish;
  end

  // stimulus
  initial begin
    rst = 1'b1;
    char_valid = 1'b0;
    char_code = '0;
    end_of_message = 1'b0;
    idling_on = 1'b1;
    drained_once = 1'b0;
    mismatches = 0;
    items_sent = 0;
    foreach (sextet_lut[i]) sextet_lut[i] = '0;
    for (int v = 0; v < 64; v++) sextet_lut[alpha_char(6'(v))] = {1'b1, 6'(v)};
    clear_decode_state();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) send_char(directed_rows[i]);

    // random messages, with a stretch free of idling and one full drain
    while (items_sent < ItemTarget) begin
      idling_on = (items_sent < 60 || items_sent >= 100);
      if (!drained_once && items_sent >= 130) begin
        drain_bytes();
        drained_once = 1'b1;
      end
      send_message();
    end
    @(negedge clk);
    char_valid = 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (EndCycles) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_decoder.sv
sv/b64d_checker.sv
tb/tb_top.sv
